@@ rtl/llfb_pkg.sv @@
// Shared constants, codes and interface types for the light level filter block.
// No dependencies.
package llfb_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int IDX_W       = 3;
  localparam int ACC_W       = SAMPLE_BITS + 8;
  localparam int LEVEL_W     = SAMPLE_BITS + 1;
  localparam int PCT_W       = 7;
  localparam int ALPHA_W     = 9;
  localparam int CNT_W       = 4;
  localparam int MASK_W      = 8;
  localparam int PROD_W      = ALPHA_W + ACC_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int NUM_W       = SAMPLE_BITS + PCT_W;
  localparam int DVS_W       = LEVEL_W + PCT_W;
  localparam int ADDR_W      = 5;

  localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  localparam logic [1:0] OP_INIT       = 2'd0;
  localparam logic [1:0] OP_SAMPLE     = 2'd1;
  localparam logic [1:0] OP_CAP_DARK   = 2'd2;
  localparam logic [1:0] OP_CAP_BRIGHT = 2'd3;

  localparam logic [2:0] REG_ALPHA    = 3'd0;
  localparam logic [2:0] REG_BTN_ON   = 3'd1;
  localparam logic [2:0] REG_BTN_OFF  = 3'd2;
  localparam logic [2:0] REG_BTN_MASK = 3'd3;
  localparam logic [2:0] REG_COUNT    = 3'd4;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [PCT_W-1:0]   btn_on;
    logic [PCT_W-1:0]   btn_off;
    logic [MASK_W-1:0]  btn_mask;
    logic [CNT_W-1:0]   count;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul_a;
    logic mul_b;
    logic prep;
    logic div_chk;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_sample;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [IDX_W-1:0]       idx;
    logic [SAMPLE_BITS-1:0] filt;
    logic [PCT_W-1:0]       pct;
    logic                   btn;
    logic [LEVEL_W-1:0]     dark;
    logic [LEVEL_W-1:0]     bright;
    logic                   err;
  } res_t;

  // (acc + 0.5 LSB) >> 8, round half up
  function automatic logic [SAMPLE_BITS-1:0] round_level(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W+1)'(128);
    return s[ACC_W-1:8];
  endfunction

endpackage

@@ rtl/llfb_ctrl.sv @@
// Sequencer for the light level filter: multiply, prepare, divide, write back.
// Depends on llfb_pkg.
module llfb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  llfb_pkg::sts_t sts_i,
  output llfb_pkg::cmd_t cmd_o
);
  import llfb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULA  = 3'd1;
  localparam logic [2:0] S_MULB  = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DCHK  = 3'd4;
  localparam logic [2:0] S_DSTEP = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [2:0] LAST_STEP = 3'(PCT_W - 1);

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MULA;
        end
      end
      S_MULA: begin
        if (sts_i.is_sample) begin
          cmd_o.mul_a = 1'b1;
          state_d     = S_MULB;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DCHK;
      end
      S_DCHK: begin
        cmd_o.div_chk = 1'b1;
        step_d        = '0;
        state_d       = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 3'd1;
        if (step_q == LAST_STEP) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ rtl/llfb_dpath.sv @@
// Datapath: per-channel state, shared multiplier, serial divider, result register.
// Depends on llfb_pkg; driven by llfb_ctrl commands.
module llfb_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  llfb_pkg::cfg_t                   cfg_i,
  input  llfb_pkg::cmd_t                   cmd_i,
  output llfb_pkg::sts_t                   sts_o,
  input  logic [1:0]                       operation_i,
  input  logic [llfb_pkg::IDX_W-1:0]       sensor_index_i,
  input  logic [llfb_pkg::SAMPLE_BITS-1:0] raw_sample_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output llfb_pkg::res_t                   res_o
);
  import llfb_pkg::*;

  logic [1:0]             op_q;
  logic [IDX_W-1:0]       idx_q;
  logic [SAMPLE_BITS-1:0] raw_q;
  logic                   err_q;

  logic [ACC_W-1:0]   acc_q    [NUM_SENSORS];
  logic [PCT_W-1:0]   pct_q    [NUM_SENSORS];
  logic [LEVEL_W-1:0] dark_q   [NUM_SENSORS];
  logic [LEVEL_W-1:0] bright_q [NUM_SENSORS];
  logic               btn_q    [NUM_SENSORS];

  logic [SUM_W-1:0]   sum_q;
  logic [NUM_W-1:0]   rem_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [PCT_W-1:0]   quo_q;
  logic               sat_q;
  logic               out_valid_q;
  res_t               res_q, res_d;

  // multiplier operands
  logic [ALPHA_W-1:0] a_eff;
  logic [ALPHA_W-1:0] mul_x;
  logic [ACC_W-1:0]   mul_y;
  logic [PROD_W-1:0]  prod;

  assign a_eff = (cfg_i.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha;
  assign mul_x = cmd_i.mul_b ? (ALPHA_ONE - a_eff) : a_eff;
  assign mul_y = cmd_i.mul_b ? acc_q[idx_q] : {raw_q, 8'd0};
  assign prod  = PROD_W'(mul_x) * PROD_W'(mul_y);

  // percentage setup
  logic [ACC_W-1:0]       acc_new;
  logic [SAMPLE_BITS-1:0] filt_new;
  logic [LEVEL_W:0]       diff;
  logic [LEVEL_W:0]       span;
  logic [LEVEL_W-1:0]     denom;
  logic [NUM_W:0]         num_full;
  logic                   num_pos;

  assign acc_new  = sum_q[ACC_W+7:8];
  assign filt_new = round_level(acc_new);
  assign diff     = {2'b00, filt_new} - {1'b0, dark_q[idx_q]};
  assign span     = {1'b0, bright_q[idx_q]} - {1'b0, dark_q[idx_q]};
  assign num_pos  = !diff[LEVEL_W] && (diff != '0);
  assign denom    = (span[LEVEL_W] || span == '0) ? LEVEL_W'(1) : span[LEVEL_W-1:0];
  assign num_full = (NUM_W+1)'(diff[SAMPLE_BITS-1:0]) * (NUM_W+1)'(PCT_MAX);

  logic div_ge;
  assign div_ge = {1'b0, rem_q} >= dvs_q;

  // write-back values
  logic [SAMPLE_BITS-1:0] filt_cur;
  logic [PCT_W-1:0]       pct_fin;
  logic [ACC_W-1:0]       acc_w;
  logic [LEVEL_W-1:0]     dark_w, bright_w;
  logic [PCT_W-1:0]       pct_w;
  logic                   btn_w, btn_cur;
  logic                   do_write;

  assign filt_cur = round_level(acc_q[idx_q]);
  assign pct_fin  = (sat_q || quo_q > PCT_MAX) ? PCT_MAX : quo_q;
  assign btn_cur  = btn_q[idx_q];
  assign do_write = cmd_i.finish && !err_q;

  always_comb begin
    acc_w    = acc_q[idx_q];
    dark_w   = dark_q[idx_q];
    bright_w = bright_q[idx_q];
    pct_w    = pct_q[idx_q];
    btn_w    = btn_cur;
    case (op_q)
      OP_INIT: begin
        acc_w    = {raw_q, 8'd0};
        dark_w   = {1'b0, raw_q};
        bright_w = {1'b0, raw_q} + LEVEL_W'(PCT_MAX);
      end
      OP_SAMPLE: begin
        pct_w = pct_fin;
        if (cfg_i.btn_mask[idx_q]) begin
          if (!btn_cur && pct_fin >= cfg_i.btn_on) begin
            btn_w = 1'b1;
          end else if (btn_cur && pct_fin <= cfg_i.btn_off) begin
            btn_w = 1'b0;
          end
        end
      end
      OP_CAP_DARK: begin
        dark_w = {1'b0, filt_cur};
      end
      OP_CAP_BRIGHT: begin
        bright_w = {1'b0, filt_cur};
      end
      default: begin
        acc_w = acc_q[idx_q];
      end
    endcase
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= operation_i;
      idx_q <= sensor_index_i;
      raw_q <= raw_sample_i;
      err_q <= {1'b0, sensor_index_i} >= cfg_i.count;
    end
  end

  // multiply-accumulate and serial divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      sum_q <= SUM_W'(prod) + SUM_W'(128);
    end else if (cmd_i.mul_b) begin
      sum_q <= sum_q + SUM_W'(prod);
    end
    if (cmd_i.prep) begin
      rem_q <= num_pos ? num_full[NUM_W-1:0] : '0;
      dvs_q <= {denom, {PCT_W{1'b0}}};
    end else if (cmd_i.div_chk) begin
      sat_q <= div_ge;
      quo_q <= '0;
      dvs_q <= dvs_q >> 1;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dvs_q[NUM_W-1:0];
      end
      quo_q <= {quo_q[PCT_W-2:0], div_ge};
      dvs_q <= dvs_q >> 1;
    end
  end

  // per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        acc_q[i]    <= '0;
        pct_q[i]    <= '0;
        dark_q[i]   <= '0;
        bright_q[i] <= '0;
        btn_q[i]    <= 1'b0;
      end
    end else begin
      if (cmd_i.prep) begin
        acc_q[idx_q] <= acc_new;
      end else if (do_write) begin
        acc_q[idx_q]    <= acc_w;
        pct_q[idx_q]    <= pct_w;
        dark_q[idx_q]   <= dark_w;
        bright_q[idx_q] <= bright_w;
        btn_q[idx_q]    <= btn_w;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    res_d     = '0;
    res_d.idx = idx_q;
    res_d.err = err_q;
    if (!err_q) begin
      res_d.filt   = round_level(acc_w);
      res_d.pct    = pct_w;
      res_d.btn    = btn_w;
      res_d.dark   = dark_w;
      res_d.bright = bright_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign sts_o.is_sample = !err_q && (op_q == OP_SAMPLE);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign res_o           = res_q;

endmodule

@@ rtl/light_level_filter_and_button.sv @@
// Light level filter and virtual button: top level with configuration registers.
// Depends on llfb_pkg, llfb_ctrl and llfb_dpath.
//
// Usage: one request on the input channel (operation, sensor_index, raw_sample)
// gives one result on the output channel for the addressed channel. Both use
// valid/ready. Registers sit on the APB port at 4*index; the user must write
// them only while the block is idle; the block itself does not enforce this.
// A sample forms the alpha and (1 - alpha) products in turn on the shared 9x20
// multiplier, then runs a setup step, one saturation check and seven restoring
// divider steps, then write-back; init, capture and out-of-range requests go
// straight to write-back. A new request is accepted in the cycle after the
// result is loaded, so the block takes one request at a time.
// The result register holds one result; while the receiver stalls, the next
// request is still accepted and processed, then held in write-back until the
// result register frees.
// Reset clears all channel state to zero and loads the register defaults.
module light_level_filter_and_button (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       operation_i,
  input  logic [llfb_pkg::IDX_W-1:0]       sensor_index_i,
  input  logic [llfb_pkg::SAMPLE_BITS-1:0] raw_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [llfb_pkg::IDX_W-1:0]       sensor_index_out_o,
  output logic [llfb_pkg::SAMPLE_BITS-1:0] filtered_level_o,
  output logic [llfb_pkg::PCT_W-1:0]       percent_o,
  output logic                             button_on_o,
  output logic [llfb_pkg::LEVEL_W-1:0]     dark_level_out_o,
  output logic [llfb_pkg::LEVEL_W-1:0]     bright_level_out_o,
  output logic                             index_error_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [llfb_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import llfb_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  res_t res;

  logic       reg_wr;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha    <= 9'd26;
      cfg_q.btn_on   <= 7'd60;
      cfg_q.btn_off  <= 7'd40;
      cfg_q.btn_mask <= '0;
      cfg_q.count    <= '0;
    end else if (reg_wr) begin
      case (reg_sel)
        REG_ALPHA:    cfg_q.alpha    <= pwdata[ALPHA_W-1:0];
        REG_BTN_ON:   cfg_q.btn_on   <= pwdata[PCT_W-1:0];
        REG_BTN_OFF:  cfg_q.btn_off  <= pwdata[PCT_W-1:0];
        REG_BTN_MASK: cfg_q.btn_mask <= pwdata[MASK_W-1:0];
        REG_COUNT:    cfg_q.count    <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ALPHA:    prdata = 32'(cfg_q.alpha);
      REG_BTN_ON:   prdata = 32'(cfg_q.btn_on);
      REG_BTN_OFF:  prdata = 32'(cfg_q.btn_off);
      REG_BTN_MASK: prdata = 32'(cfg_q.btn_mask);
      REG_COUNT:    prdata = 32'(cfg_q.count);
      default:      prdata = '0;
    endcase
  end

  llfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  llfb_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .sensor_index_i (sensor_index_i),
    .raw_sample_i   (raw_sample_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .res_o          (res)
  );

  assign sensor_index_out_o = res.idx;
  assign filtered_level_o   = res.filt;
  assign percent_o          = res.pct;
  assign button_on_o        = res.btn;
  assign dark_level_out_o   = res.dark;
  assign bright_level_out_o = res.bright;
  assign index_error_o      = res.err;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && index_error_o) |-> (filtered_level_o == '0 && percent_o == '0 &&
      !button_on_o && dark_level_out_o == '0 && bright_level_out_o == '0))
    else $error("out-of-range result carries channel data");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (percent_o <= PCT_MAX))
    else $error("percentage above 100");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sensor_index_out_o)))
    else $error("stalled result lost");

endmodule
